>>> hdl/idrc_pkg.sv
package idrc_pkg;

    localparam int COORD_BITS = 18;
    localparam int DSQ_W      = 2 * COORD_BITS + 1;
    localparam int DIST_W     = COORD_BITS + 1;
    localparam int RSQ_W      = 2 * COORD_BITS;
    localparam int NCELLS     = COORD_BITS + 1;

    typedef struct packed {
        logic [DSQ_W-1:0] dsq;
        logic [DSQ_W-1:0] rem;
        logic [DSQ_W-1:0] root;
        logic             in_range;
    } idrc_word_t;

    // trial bit of cell i: 4^(COORD_BITS - i)
    function automatic logic [DSQ_W-1:0] cell_bit(input int i);
        logic [DSQ_W-1:0] one;
        one = {{(DSQ_W-1){1'b0}}, 1'b1};
        return one << (2 * (COORD_BITS - i));
    endfunction

endpackage

>>> hdl/idrc_front.sv
module idrc_front
    import idrc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_BITS-1:0] a_x,
    input  logic [COORD_BITS-1:0] a_y,
    input  logic [COORD_BITS-1:0] b_x,
    input  logic [COORD_BITS-1:0] b_y,
    input  logic [COORD_BITS-1:0] sight_range,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DSQ_W-1:0]      dsq,
    output logic [RSQ_W-1:0]      rsq,
    output logic                  range_nz
);

    logic                  v1_reg, v2_reg, v3_reg;
    logic                  rdy1, rdy2, rdy3;
    logic [COORD_BITS:0]   diff_x, diff_y;
    logic [COORD_BITS-1:0] dx_next, dy_next;
    logic [COORD_BITS-1:0] dx_reg, dy_reg, rng_reg;
    logic                  rnz1_reg, rnz2_reg, rnz3_reg;
    logic [RSQ_W-1:0]      sqx_reg, sqy_reg, rsq2_reg, rsq3_reg;
    logic [DSQ_W-1:0]      dsq_reg;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign diff_x  = {a_x[COORD_BITS-1], a_x} - {b_x[COORD_BITS-1], b_x};
    assign diff_y  = {a_y[COORD_BITS-1], a_y} - {b_y[COORD_BITS-1], b_y};
    assign dx_next = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
    assign dy_next = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            rng_reg  <= sight_range;
            rnz1_reg <= (sight_range != '0);
        end
        if (rdy2) begin
            sqx_reg  <= RSQ_W'(dx_reg) * RSQ_W'(dx_reg);
            sqy_reg  <= RSQ_W'(dy_reg) * RSQ_W'(dy_reg);
            rsq2_reg <= RSQ_W'(rng_reg) * RSQ_W'(rng_reg);
            rnz2_reg <= rnz1_reg;
        end
        if (rdy3) begin
            dsq_reg  <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
            rsq3_reg <= rsq2_reg;
            rnz3_reg <= rnz2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign dsq       = dsq_reg;
    assign rsq       = rsq3_reg;
    assign range_nz  = rnz3_reg;

endmodule

>>> hdl/idrc_sqrt_cell.sv
module idrc_sqrt_cell
    import idrc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [DSQ_W-1:0] trial_bit,
    input  logic             in_valid,
    output logic             in_ready,
    input  idrc_word_t       in_word,
    output logic             out_valid,
    input  logic             out_ready,
    output idrc_word_t       out_word
);

    logic             v_reg;
    idrc_word_t       word_reg, word_next;
    logic [DSQ_W:0]   trial;
    logic             take;

    assign in_ready = !v_reg || out_ready;

    assign trial = {1'b0, in_word.root} + {1'b0, trial_bit};
    assign take  = {1'b0, in_word.rem} >= trial;

    always_comb begin
        word_next = in_word;
        if (take) begin
            word_next.rem  = in_word.rem - trial[DSQ_W-1:0];
            word_next.root = (in_word.root >> 1) + trial_bit;
        end else begin
            word_next.root = in_word.root >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = v_reg;
    assign out_word  = word_reg;

endmodule

>>> hdl/integer_distance_2d_with_range_check_unit.sv
// channel | ports                                   | dir | handshake
// input   | s_a_x s_a_y s_b_x s_b_y s_sight_range   | in  | s_valid / s_ready
// result  | m_dist_squared m_distance m_in_range    | out | m_valid / m_ready
//
// One word in and one word out per cycle while the output is not stalled; 3 front stages for
// difference, square and sum, then one square-root cell per result bit, 19 in all.
// Every stage holds its own valid bit and stalls only when its successor is full,
// so the input keeps taking words while a result waits at the output.
// Reset (aresetn low at a clock edge) empties the pipeline.
module integer_distance_2d_with_range_check_unit
    import idrc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COORD_BITS-1:0] s_a_x,
    input  logic [COORD_BITS-1:0] s_a_y,
    input  logic [COORD_BITS-1:0] s_b_x,
    input  logic [COORD_BITS-1:0] s_b_y,
    input  logic [COORD_BITS-1:0] s_sight_range,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DSQ_W-1:0]      m_dist_squared,
    output logic [DIST_W-1:0]     m_distance,
    output logic                  m_in_range
);

    logic             f_valid;
    logic [DSQ_W-1:0] f_dsq;
    logic [RSQ_W-1:0] f_rsq;
    logic             f_rnz;

    logic             c_valid [0:NCELLS];
    logic             c_ready [0:NCELLS];
    idrc_word_t       c_word  [0:NCELLS];

    idrc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .a_x         (s_a_x),
        .a_y         (s_a_y),
        .b_x         (s_b_x),
        .b_y         (s_b_y),
        .sight_range (s_sight_range),
        .out_valid   (f_valid),
        .out_ready   (c_ready[0]),
        .dsq         (f_dsq),
        .rsq         (f_rsq),
        .range_nz    (f_rnz)
    );

    assign c_valid[0]         = f_valid;
    assign c_word[0].dsq      = f_dsq;
    assign c_word[0].rem      = f_dsq;
    assign c_word[0].root     = '0;
    assign c_word[0].in_range = f_rnz && (f_dsq <= {1'b0, f_rsq});

    for (genvar i = 0; i < NCELLS; i++) begin : g_cell
        idrc_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .trial_bit (cell_bit(i)),
            .in_valid  (c_valid[i]),
            .in_ready  (c_ready[i]),
            .in_word   (c_word[i]),
            .out_valid (c_valid[i+1]),
            .out_ready (c_ready[i+1]),
            .out_word  (c_word[i+1])
        );
    end

    assign c_ready[NCELLS] = m_ready;
    assign m_valid         = c_valid[NCELLS];
    assign m_dist_squared  = c_word[NCELLS].dsq;
    assign m_distance      = c_word[NCELLS].root[DIST_W-1:0];
    assign m_in_range      = c_word[NCELLS].in_range;

endmodule

>>> hdl/idrc_checker.sv
module idrc_checker
    import idrc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [DSQ_W-1:0]      m_dist_squared,
    input  logic [DIST_W-1:0]     m_distance,
    input  logic                  m_in_range
);

    logic [2*DIST_W-1:0] d_sq;
    logic [2*DIST_W-1:0] d1_sq;

    assign d_sq  = (2*DIST_W)'(m_distance) * (2*DIST_W)'(m_distance);
    assign d1_sq = ((2*DIST_W)'(m_distance) + 1'b1) * ((2*DIST_W)'(m_distance) + 1'b1);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word valid right after reset");

    a_root_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> d_sq <= (2*DIST_W)'(m_dist_squared))
        else $error("distance too large for squared distance");

    a_root_high: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> d1_sq > (2*DIST_W)'(m_dist_squared))
        else $error("distance too small for squared distance");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_dist_squared)
                                && $stable(m_distance) && $stable(m_in_range))
        else $error("stalled result word changed");

endmodule

bind integer_distance_2d_with_range_check_unit idrc_checker u_idrc_checker (.*);

>>> tb/sv/tb_integer_distance_2d_with_range_check_unit.sv
module tb_integer_distance_2d_with_range_check_unit;
    import idrc_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_REPORTS   = 50;
    localparam int RANDOM_WORDS  = 320;
    localparam int NPHASE        = 4;
    localparam int NPROBE        = 18;

    localparam logic [COORD_BITS-1:0] C_ZERO = '0;
    localparam logic [COORD_BITS-1:0] C_MIN  = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic [COORD_BITS-1:0] C_MAX  = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic [COORD_BITS-1:0] C_NEG1 = '1;
    localparam logic [COORD_BITS-1:0] R_MAX  = '1;

    typedef struct packed {
        logic [DSQ_W-1:0]  dsq;
        logic [DIST_W-1:0] distance;
        logic              inr;
    } range_result_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] ax;
        logic [COORD_BITS-1:0] ay;
        logic [COORD_BITS-1:0] bx;
        logic [COORD_BITS-1:0] by;
        logic [COORD_BITS-1:0] rng;
        logic                  typed;
        logic [DSQ_W-1:0]      dsq;
        logic [DIST_W-1:0]     distance;
        logic                  inr;
    } probe_t;

    // typed rows carry a hand-computed result, the rest go through the predictor
    localparam probe_t PROBES [NPROBE] = '{
        '{C_ZERO, C_ZERO, C_ZERO, C_ZERO, C_ZERO, 1'b1, 37'd0, 19'd0, 1'b0},
        '{18'd5, -18'sd7, 18'd5, -18'sd7, 18'd1, 1'b1, 37'd0, 19'd0, 1'b1},
        '{C_MIN, C_MAX, C_MIN, C_MAX, R_MAX, 1'b1, 37'd0, 19'd0, 1'b1},
        '{C_MIN, C_ZERO, C_MAX, C_ZERO, R_MAX, 1'b1, 37'd68718952449, 19'd262143, 1'b1},
        '{C_MAX, C_MIN, C_MIN, C_MAX, R_MAX, 1'b1, 37'd137437904898, 19'd370726, 1'b0},
        '{C_MAX, C_MIN, C_MIN, C_MAX, C_ZERO, 1'b1, 37'd137437904898, 19'd370726, 1'b0},
        '{C_ZERO, C_ZERO, 18'd3, 18'd4, 18'd5, 1'b1, 37'd25, 19'd5, 1'b1},
        '{C_ZERO, C_ZERO, 18'd3, 18'd4, 18'd4, 1'b1, 37'd25, 19'd5, 1'b0},
        '{C_ZERO, C_ZERO, -18'sd5, 18'd1, 18'd5, 1'b1, 37'd26, 19'd5, 1'b0},
        '{C_NEG1, C_NEG1, 18'd1, 18'd1, 18'd3, 1'b1, 37'd8, 19'd2, 1'b1},
        '{C_ZERO, C_ZERO, 18'd1, C_NEG1, 18'd1, 1'b1, 37'd2, 19'd1, 1'b0},
        '{C_MIN, C_ZERO, C_ZERO, C_ZERO, 18'd131072, 1'b1, 37'd17179869184, 19'd131072,
          1'b1},
        '{C_ZERO, C_MAX, C_ZERO, C_MIN, C_ZERO, 1'b1, 37'd68718952449, 19'd262143, 1'b0},
        '{18'd1000, -18'sd2000, -18'sd3000, 18'd4500, 18'd7000, 1'b0, 37'd0, 19'd0, 1'b0},
        '{18'd12345, -18'sd54321, -18'sd99999, 18'd77777, 18'd200000, 1'b0, 37'd0, 19'd0,
          1'b0},
        '{C_MAX, C_MAX, C_ZERO, C_ZERO, 18'd185363, 1'b0, 37'd0, 19'd0, 1'b0},
        '{C_NEG1, C_ZERO, C_ZERO, C_NEG1, R_MAX, 1'b0, 37'd0, 19'd0, 1'b0},
        '{18'd77, 18'd88, 18'd77, 18'd88, C_ZERO, 1'b1, 37'd0, 19'd0, 1'b0}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [COORD_BITS-1:0] s_a_x = '0;
    logic [COORD_BITS-1:0] s_a_y = '0;
    logic [COORD_BITS-1:0] s_b_x = '0;
    logic [COORD_BITS-1:0] s_b_y = '0;
    logic [COORD_BITS-1:0] s_sight_range = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [DSQ_W-1:0]      m_dist_squared;
    logic [DIST_W-1:0]     m_distance;
    logic                  m_in_range;

    range_result_t pending_results[$];
    int            fail_count = 0;
    int            report_count = 0;
    int            cycle_count = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    logic          cur_typed = 1'b0;
    range_result_t cur_expect = '0;

    integer_distance_2d_with_range_check_unit u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_a_x          (s_a_x),
        .s_a_y          (s_a_y),
        .s_b_x          (s_b_x),
        .s_b_y          (s_b_y),
        .s_sight_range  (s_sight_range),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_dist_squared (m_dist_squared),
        .m_distance     (m_distance),
        .m_in_range     (m_in_range)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic range_result_t predict_range_result(
        input logic [COORD_BITS-1:0] ax, input logic [COORD_BITS-1:0] ay,
        input logic [COORD_BITS-1:0] bx, input logic [COORD_BITS-1:0] by,
        input logic [COORD_BITS-1:0] rng);
        longint          dx;
        longint          dy;
        longint unsigned sq;
        longint unsigned rem;
        longint unsigned root;
        longint unsigned trial;
        longint unsigned rsq;
        range_result_t   r;
        dx = longint'($signed(ax)) - longint'($signed(bx));
        dy = longint'($signed(ay)) - longint'($signed(by));
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        sq = longint'(dx * dx + dy * dy);
        rem = sq;
        root = 0;
        trial = 64'd1 << (2 * COORD_BITS);
        while (trial > sq) trial = trial >> 2;
        while (trial != 0) begin
            if (rem >= root + trial) begin
                rem = rem - (root + trial);
                root = (root >> 1) + trial;
            end else begin
                root = root >> 1;
            end
            trial = trial >> 2;
        end
        rsq = longint'(rng) * longint'(rng);
        r.dsq = sq[DSQ_W-1:0];
        r.distance = root[DIST_W-1:0];
        r.inr = (rng != '0) && (sq <= rsq);
        return r;
    endfunction

    function automatic logic [COORD_BITS-1:0] edge_coord();
        case ($urandom_range(0, 5))
            0: return C_MIN;
            1: return C_MAX;
            2: return C_ZERO;
            3: return C_NEG1;
            4: return COORD_BITS'(1);
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    task automatic make_random_word(
        output logic [COORD_BITS-1:0] ax, output logic [COORD_BITS-1:0] ay,
        output logic [COORD_BITS-1:0] bx, output logic [COORD_BITS-1:0] by,
        output logic [COORD_BITS-1:0] rng);
        int            mode;
        int            span;
        longint        target;
        range_result_t r;
        mode = $urandom_range(0, 99);
        ax = COORD_BITS'($urandom);
        ay = COORD_BITS'($urandom);
        bx = COORD_BITS'($urandom);
        by = COORD_BITS'($urandom);
        rng = COORD_BITS'($urandom);
        if (mode < 25) begin
        end else if (mode < 60) begin
            // nearby target, range of the same order as the offset
            span = 1 << $urandom_range(0, COORD_BITS - 1);
            bx = ax + COORD_BITS'($urandom_range(0, 2 * span) - span);
            by = ay + COORD_BITS'($urandom_range(0, 2 * span) - span);
            rng = COORD_BITS'($urandom_range(0, 2 * span));
        end else if (mode < 85) begin
            // range within one of the integer distance, now and then zero
            r = predict_range_result(ax, ay, bx, by, C_ZERO);
            target = longint'(r.distance) + longint'($urandom_range(0, 2)) - 1;
            if (target < 0) target = 0;
            if (target > longint'(R_MAX)) target = longint'(R_MAX);
            rng = COORD_BITS'(target);
            if ($urandom_range(0, 7) == 0) rng = C_ZERO;
        end else begin
            ax = edge_coord();
            ay = edge_coord();
            bx = edge_coord();
            by = edge_coord();
            case ($urandom_range(0, 3))
                0: rng = C_ZERO;
                1: rng = COORD_BITS'(1);
                2: rng = R_MAX;
                default: rng = COORD_BITS'($urandom);
            endcase
        end
    endtask

    task automatic send_word(
        input logic [COORD_BITS-1:0] ax, input logic [COORD_BITS-1:0] ay,
        input logic [COORD_BITS-1:0] bx, input logic [COORD_BITS-1:0] by,
        input logic [COORD_BITS-1:0] rng, input logic typed, input range_result_t want);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_a_x <= ax;
        s_a_y <= ay;
        s_b_x <= bx;
        s_b_y <= by;
        s_sight_range <= rng;
        s_valid <= 1'b1;
        cur_typed = typed;
        cur_expect = want;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic report_mismatch(input string field, input longint unsigned want,
                                   input longint unsigned got);
        fail_count++;
        if (report_count < MAX_REPORTS) begin
            report_count++;
            $display("%0t mismatch %s expected %0d actual %0d", $time, field, want, got);
        end
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin : result_check
        range_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    fail_count++;
                    if (report_count < MAX_REPORTS) begin
                        report_count++;
                        $display("%0t unexpected word expected none actual %0d %0d %0d",
                                 $time, m_dist_squared, m_distance, m_in_range);
                    end
                end else begin
                    want = pending_results.pop_front();
                    if (m_dist_squared !== want.dsq)
                        report_mismatch("dist_squared", want.dsq, m_dist_squared);
                    if (m_distance !== want.distance)
                        report_mismatch("distance", want.distance, m_distance);
                    if (m_in_range !== want.inr)
                        report_mismatch("in_range", want.inr, m_in_range);
                end
            end
            if (s_valid && s_ready) begin
                if (cur_typed)
                    pending_results.push_back(cur_expect);
                else
                    pending_results.push_back(predict_range_result(
                        s_a_x, s_a_y, s_b_x, s_b_y, s_sight_range));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        logic [COORD_BITS-1:0] ax;
        logic [COORD_BITS-1:0] ay;
        logic [COORD_BITS-1:0] bx;
        logic [COORD_BITS-1:0] by;
        logic [COORD_BITS-1:0] rng;
        int                    send_plan [NPHASE];
        int                    recv_plan [NPHASE];
        send_plan = '{0, 86, 0, 32};
        recv_plan = '{0, 0, 86, 32};
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (PROBES[i]) begin
            send_word(PROBES[i].ax, PROBES[i].ay, PROBES[i].bx, PROBES[i].by,
                      PROBES[i].rng, PROBES[i].typed,
                      '{PROBES[i].dsq, PROBES[i].distance, PROBES[i].inr});
        end
        drain_results();

        for (int p = 0; p < NPHASE; p++) begin
            send_idle_pct = send_plan[p];
            recv_stall_pct = recv_plan[p];
            repeat (RANDOM_WORDS) begin
                make_random_word(ax, ay, bx, by, rng);
                send_word(ax, ay, bx, by, rng, 1'b0, '0);
            end
            // hold the input until the pipe is empty
            drain_results();
        end

        repeat (40) @(posedge aclk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
